// ----- hw/rtl/bpdc_pkg.sv -----
// Package for the button press duration classifier.
// Holds the counter width, phase and event codes, and the threshold bundle.
// Depends on nothing; every other file imports it.
package bpdc_pkg;

    localparam int TICK_COUNT_BITS = 16;
    localparam int THR_W = 16;
    localparam int CMP_W = (TICK_COUNT_BITS > THR_W) ? TICK_COUNT_BITS : THR_W;
    localparam int CODE_W = 3;
    localparam int CFG_ADDR_W = 2;

    localparam logic [THR_W-1:0] SHORT_RESET = 16'd100;
    localparam logic [THR_W-1:0] LONG_RESET = 16'd1000;
    localparam logic [THR_W-1:0] SUPER_RESET = 16'd2000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SHORT = 2'd0,
        REG_LONG = 2'd1,
        REG_SUPER = 2'd2
    } t_reg_index;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_MAYBE = 5'b00010,
        PH_SHORT = 5'b00100,
        PH_LONG = 5'b01000,
        PH_SUPER = 5'b10000
    } t_phase;

    localparam logic [CODE_W-1:0] CODE_IDLE = 3'd0;
    localparam logic [CODE_W-1:0] CODE_MAYBE = 3'd1;
    localparam logic [CODE_W-1:0] CODE_SHORT = 3'd2;
    localparam logic [CODE_W-1:0] CODE_LONG = 3'd3;
    localparam logic [CODE_W-1:0] CODE_SUPER = 3'd4;

    localparam logic [CODE_W-1:0] EV_NONE = 3'd0;
    localparam logic [CODE_W-1:0] EV_SHORT_REL = 3'd1;
    localparam logic [CODE_W-1:0] EV_LONG_ARM = 3'd2;
    localparam logic [CODE_W-1:0] EV_LONG_REL = 3'd3;
    localparam logic [CODE_W-1:0] EV_SUPER_ARM = 3'd4;

    typedef struct packed {
        logic [THR_W-1:0] short_ticks;
        logic [THR_W-1:0] long_ticks;
        logic [THR_W-1:0] super_ticks;
    } t_thresholds;

    function automatic logic [CODE_W-1:0] phase_code(input t_phase ph);
        logic [CODE_W-1:0] code;
        case (ph)
            PH_MAYBE: code = CODE_MAYBE;
            PH_SHORT: code = CODE_SHORT;
            PH_LONG: code = CODE_LONG;
            PH_SUPER: code = CODE_SUPER;
            default: code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ----- hw/rtl/bpdc_cfg_regs.sv -----
// Threshold registers of the button press duration classifier.
// Written through the plain write port; depends on bpdc_pkg.
module bpdc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bpdc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bpdc_pkg::THR_W-1:0]      i_cfg_wdata,
    output bpdc_pkg::t_thresholds           o_thr
);
    import bpdc_pkg::*;

    t_thresholds r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.short_ticks <= SHORT_RESET;
            r_thr.long_ticks <= LONG_RESET;
            r_thr.super_ticks <= SUPER_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SHORT: r_thr.short_ticks <= i_cfg_wdata;
                REG_LONG: r_thr.long_ticks <= i_cfg_wdata;
                REG_SUPER: r_thr.super_ticks <= i_cfg_wdata;
                default: r_thr <= r_thr;
            endcase
        end
    end

    assign o_thr = r_thr;

endmodule

// ----- hw/rtl/bpdc_core.sv -----
// Press phase state, saturating tick counter and result register.
// Processes one registered contact sample per fire strobe; depends on bpdc_pkg.
module bpdc_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic                         i_contact,
    input  bpdc_pkg::t_thresholds        i_thr,
    output logic [bpdc_pkg::CODE_W-1:0]  o_event_code,
    output logic [bpdc_pkg::CODE_W-1:0]  o_press_state
);
    import bpdc_pkg::*;

    localparam logic [TICK_COUNT_BITS-1:0] TICK_MAX = '1;

    t_phase                     r_phase, n_phase;
    logic [TICK_COUNT_BITS-1:0] r_elapsed, n_elapsed;
    logic [CODE_W-1:0]          r_event, n_event;
    logic [CODE_W-1:0]          r_state_code;
    logic [TICK_COUNT_BITS-1:0] elapsed_inc;
    logic [THR_W-1:0]           limit;
    logic                       reach;

    assign elapsed_inc = (r_elapsed == TICK_MAX) ? r_elapsed : r_elapsed + 1'b1;

    always_comb begin
        case (r_phase)
            PH_MAYBE: limit = i_thr.short_ticks;
            PH_SHORT: limit = i_thr.long_ticks;
            default: limit = i_thr.super_ticks;
        endcase
    end

    assign reach = CMP_W'(elapsed_inc) >= CMP_W'(limit);

    always_comb begin
        n_phase = r_phase;
        n_elapsed = elapsed_inc;
        n_event = EV_NONE;
        case (r_phase)
            PH_MAYBE: begin
                if (!i_contact) begin
                    n_phase = PH_IDLE;
                    n_elapsed = '0;
                end else if (reach) begin
                    n_phase = PH_SHORT;
                    n_elapsed = '0;
                end
            end
            PH_SHORT: begin
                if (!i_contact) begin
                    n_event = EV_SHORT_REL;
                    n_phase = PH_IDLE;
                    n_elapsed = '0;
                end else if (reach) begin
                    n_event = EV_LONG_ARM;
                    n_phase = PH_LONG;
                    n_elapsed = '0;
                end
            end
            PH_LONG: begin
                if (!i_contact) begin
                    n_event = EV_LONG_REL;
                    n_phase = PH_IDLE;
                    n_elapsed = '0;
                end else if (reach) begin
                    n_event = EV_SUPER_ARM;
                    n_phase = PH_SUPER;
                    n_elapsed = '0;
                end
            end
            PH_SUPER: begin
                n_elapsed = r_elapsed;
                if (!i_contact) begin
                    n_phase = PH_IDLE;
                    n_elapsed = '0;
                end
            end
            default: begin
                n_phase = i_contact ? PH_MAYBE : PH_IDLE;
                n_elapsed = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_elapsed <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_elapsed <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_event <= n_event;
            r_state_code <= phase_code(n_phase);
        end
    end

    assign o_event_code = r_event;
    assign o_press_state = r_state_code;

endmodule

// ----- hw/rtl/button_press_duration_classifier_top.sv -----
// Top level of the button press duration classifier.
// Input register and handshake control around bpdc_cfg_regs and bpdc_core.
//
//   channel   direction  handshake                 payload
//   in        sink       i_in_valid / o_in_ready   i_contact
//   out       source     o_out_valid / i_out_ready o_event_code, o_press_state
//   cfg       sink       i_cfg_we                  i_cfg_addr, i_cfg_wdata
//
// A word passes the input register, then the phase update into the result
// register. One word per cycle is sustained unless the result stalls.
// Reset returns the phase to idle, clears the tick counter and loads the
// default thresholds. A stalled result holds both stages, and the input stays
// ready while the input register is empty.
module button_press_duration_classifier_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_contact,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bpdc_pkg::CODE_W-1:0]     o_event_code,
    output logic [bpdc_pkg::CODE_W-1:0]     o_press_state,
    input  logic                           i_cfg_we,
    input  logic [bpdc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [bpdc_pkg::THR_W-1:0]      i_cfg_wdata
);
    import bpdc_pkg::*;

    logic        r_in_vld;
    logic        r_in_contact;
    logic        r_out_vld;
    logic        fire;
    t_thresholds thr;

    assign fire = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || fire;
    assign o_out_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_contact <= i_contact;
        end
    end

    bpdc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_thr       (thr)
    );

    bpdc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_contact     (r_in_contact),
        .i_thr         (thr),
        .o_event_code  (o_event_code),
        .o_press_state (o_press_state)
    );

`ifndef SYNTHESIS
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("Processed word did not reach the result register.");

    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_press_state <= CODE_SUPER))
        else $error("Press state code out of range.");

    a_release_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_code == EV_SHORT_REL || o_event_code == EV_LONG_REL))
        |-> (o_press_state == CODE_IDLE))
        else $error("Release event without return to idle.");

    a_arm_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_code == EV_LONG_ARM) |-> (o_press_state == CODE_LONG))
        else $error("Long armed event with wrong press state.");
`endif

endmodule
